@@ rtl/core/avcpk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcpk_pkg
// Types and constants shared by the Annex-B to FLV AVC packetizer.
// ----------------------------------------------------------------------------
package avcpk_pkg;

	localparam logic [7:0] NAL_SPS   = 8'h67;
	localparam logic [7:0] NAL_PPS   = 8'h68;
	localparam logic [7:0] NAL_IDR   = 8'h65;
	localparam logic [7:0] TAG_KEY   = 8'h17;
	localparam logic [7:0] TAG_INTER = 8'h27;
	localparam logic [7:0] AVCC_FF   = 8'hFF;
	localparam logic [7:0] AVCC_E1   = 8'hE1;
	localparam logic [7:0] BYTE_01   = 8'h01;

	localparam logic [1:0] KIND_SEQ   = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_INTER = 2'd2;

	localparam int QDEPTH = 4;

	// Lead bytes of the sequence header run 0..12, then SPS, mid bytes, PPS.
	localparam logic [5:0] LEAD_LAST = 6'd12;
	localparam logic [5:0] MID_LAST  = 6'd2;
	localparam logic [5:0] HDR_LAST  = 6'd8;

	typedef enum logic [1:0] {
		FM_IDLE,
		FM_START,
		FM_CAPTURE,
		FM_TAG
	} frame_mode_t;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SPS,
		PH_MID,
		PH_PPS,
		PH_HDR,
		PH_DATA
	} phase_t;

	// One entry per input byte that produces output.
	typedef struct packed {
		logic        do_seq;
		logic        do_hdr;
		logic [7:0]  data;
		logic [1:0]  kind;
		logic        eop;
		logic [31:0] tstamp;
		logic [23:0] len;
		logic        err;
	} cmd_t;

endpackage

@@ rtl/core/avcpk_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcpk_in_if
// Annex-B byte stream channel.
// ----------------------------------------------------------------------------
interface avcpk_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  in_byte;
	logic        first_of_frame;
	logic        last_of_frame;
	logic [23:0] frame_len;
	logic [31:0] timestamp;

	modport source(output valid, in_byte, first_of_frame, last_of_frame, frame_len,
		timestamp, input ready);
	modport sink(input valid, in_byte, first_of_frame, last_of_frame, frame_len,
		timestamp, output ready);
endinterface

@@ rtl/core/avcpk_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcpk_out_if
// FLV video body byte channel.
// ----------------------------------------------------------------------------
interface avcpk_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [1:0]  packet_kind;
	logic        end_of_packet;
	logic [31:0] packet_time;
	logic        param_error;

	modport source(output valid, out_byte, packet_kind, end_of_packet, packet_time,
		param_error, input ready);
	modport sink(input valid, out_byte, packet_kind, end_of_packet, packet_time,
		param_error, output ready);
endinterface

@@ rtl/core/avcpk_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcpk_front
// Frame parser: tracks frame position, captures SPS/PPS, issues commands.
// ----------------------------------------------------------------------------
module avcpk_front import avcpk_pkg::*; #(
	parameter int MAX_SPS_BYTES = 24,
	parameter int MAX_PPS_BYTES = 8,
	parameter int SPS_CW = $clog2(MAX_SPS_BYTES + 6),
	parameter int PPS_CW = $clog2(MAX_PPS_BYTES + 2),
	parameter int SPS_AW = $clog2(MAX_SPS_BYTES),
	parameter int PPS_AW = $clog2(MAX_PPS_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	avcpk_in_if.sink          frames,
	input  logic              q_full,
	output logic              q_push,
	output cmd_t              q_cmd,
	output logic              sps_we,
	output logic [SPS_AW-1:0] sps_wa,
	output logic              pps_we,
	output logic [PPS_AW-1:0] pps_wa,
	output logic [7:0]        wr_data,
	output logic [SPS_CW-1:0] sps_cnt,
	output logic [PPS_CW-1:0] pps_cnt
);

	localparam logic [SPS_CW-1:0] SPS_MAX  = SPS_CW'(MAX_SPS_BYTES);
	localparam logic [SPS_CW-1:0] SPS_SAT  = SPS_CW'(MAX_SPS_BYTES + 5);
	localparam logic [PPS_CW-1:0] PPS_MAX  = PPS_CW'(MAX_PPS_BYTES);
	localparam logic [PPS_CW-1:0] PPS_SAT  = PPS_CW'(MAX_PPS_BYTES + 1);

	frame_mode_t       mode_q, mode_a, mode_b, mode_n;
	logic [23:0]       pos_q, p;
	logic [31:0]       recent_q;
	logic [SPS_CW-1:0] sps_q, sc, sc_n;
	logic [PPS_CW-1:0] pps_q, pc, pc_eff, pc_n;
	logic              inpps_q, inp, inp_n;
	logic              cached_q, cached_n, err_q, err_n;
	logic [23:0]       hlen_q, hl;
	logic [31:0]       htime_q, ht;
	logic [1:0]        kind_q, kind;
	logic              accept, at_start, is67, start_tag, start_cap, cap, sw, fend;

	assign frames.ready = !q_full;
	assign accept = frames.valid && !q_full;

	// decode of the current byte
	always_comb begin
		mode_a = frames.first_of_frame ? FM_START : mode_q;
		p = frames.first_of_frame ? 24'd0 : pos_q;
		at_start = (mode_a == FM_START) && (p >= 24'd4);
		is67 = frames.in_byte == NAL_SPS;
		hl = at_start ? frames.frame_len : hlen_q;
		ht = at_start ? frames.timestamp : htime_q;
		kind = at_start ? ((frames.in_byte == NAL_IDR) ? KIND_KEY : KIND_INTER) : kind_q;
		start_tag = at_start && !is67;
		start_cap = at_start && is67 && !cached_q;
		fend = frames.last_of_frame || ({1'b0, p} + 25'd1 >= {1'b0, hl});
	end

	// next state
	always_comb begin
		if (at_start)
			mode_b = is67 ? (cached_q ? FM_IDLE : FM_CAPTURE) : FM_TAG;
		else if (mode_a == FM_START && frames.last_of_frame)
			mode_b = FM_IDLE;
		else
			mode_b = mode_a;
		mode_n = ((mode_b == FM_CAPTURE || mode_b == FM_TAG) && fend) ? FM_IDLE : mode_b;

		cap = mode_b == FM_CAPTURE;
		sc = start_cap ? '0 : sps_q;
		pc = start_cap ? '0 : pps_q;
		inp = start_cap ? 1'b0 : inpps_q;
		sw = cap && !inp && sc >= SPS_CW'(5) && recent_q == 32'd1
			&& frames.in_byte == NAL_PPS;
		sc_n = sc;
		pc_n = pc;
		pc_eff = sw ? '0 : pc;
		inp_n = inp;
		cached_n = cached_q;
		err_n = err_q;
		sps_we = 1'b0;
		pps_we = 1'b0;
		if (cap) begin
			if (!inp && !sw) begin
				sps_we = sc < SPS_MAX;
				if (sc < SPS_SAT)
					sc_n = sc + SPS_CW'(1);
			end else begin
				if (sw)
					sc_n = sc - SPS_CW'(4);
				inp_n = 1'b1;
				pps_we = pc_eff < PPS_MAX;
				pc_n = (pc_eff < PPS_SAT) ? pc_eff + PPS_CW'(1) : pc_eff;
			end
			if (fend) begin
				if (inp_n && sc_n <= SPS_MAX && pc_n <= PPS_MAX) begin
					cached_n = 1'b1;
					err_n = 1'b0;
				end else begin
					if (inp_n)
						err_n = 1'b1;
					sc_n = '0;
					pc_n = '0;
				end
			end
		end
		sps_we = sps_we && accept;
		pps_we = pps_we && accept;
	end

	// command output
	always_comb begin
		q_push = accept && (mode_b == FM_TAG);
		q_cmd.do_seq = start_tag && (frames.in_byte == NAL_IDR) && cached_q;
		q_cmd.do_hdr = start_tag;
		q_cmd.data = frames.in_byte;
		q_cmd.kind = kind;
		q_cmd.eop = fend;
		q_cmd.tstamp = ht;
		q_cmd.len = (hl >= 24'd4) ? hl - 24'd4 : 24'd0;
		q_cmd.err = err_q;
	end

	assign sps_wa = sc[SPS_AW-1:0];
	assign pps_wa = pc_eff[PPS_AW-1:0];
	assign wr_data = frames.in_byte;
	assign sps_cnt = sps_q;
	assign pps_cnt = pps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= FM_IDLE;
			pos_q <= '0;
			recent_q <= '0;
			sps_q <= '0;
			pps_q <= '0;
			inpps_q <= 1'b0;
			cached_q <= 1'b0;
			err_q <= 1'b0;
			hlen_q <= '0;
			htime_q <= '0;
			kind_q <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			pos_q <= (p != 24'hFFFFFF) ? p + 24'd1 : p;
			recent_q <= {recent_q[23:0], frames.in_byte};
			sps_q <= sc_n;
			pps_q <= pc_n;
			inpps_q <= cap ? inp_n : inpps_q;
			cached_q <= cached_n;
			err_q <= err_n;
			hlen_q <= hl;
			htime_q <= ht;
			kind_q <= kind;
		end
	end

	ap_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push) else $error("push into full queue");
	ap_seq_has_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_cmd.do_seq |-> q_cmd.do_hdr && q_cmd.kind == KIND_KEY)
		else $error("sequence header without key tag");
	ap_cached_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		cached_q |=> cached_q) else $error("cache dropped");
	ap_no_write_cached: assert property (@(posedge clk) disable iff (!arst_n)
		cached_q |-> !sps_we && !pps_we) else $error("store write while cached");

endmodule

@@ rtl/core/avcpk_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcpk_queue
// Short command queue between parser and body sequencer.
// ----------------------------------------------------------------------------
module avcpk_queue import avcpk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	localparam int AW = $clog2(QDEPTH);

	cmd_t            mem [QDEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign empty = cnt_q == '0;
	assign full = cnt_q == (AW+1)'(QDEPTH);
	assign head = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + AW'(1);
			if (pop)
				rp_q <= rp_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule

@@ rtl/core/avcpk_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcpk_back
// Body sequencer: expands commands into FLV body bytes, holds the
// parameter-set stores.
// ----------------------------------------------------------------------------
module avcpk_back import avcpk_pkg::*; #(
	parameter int MAX_SPS_BYTES = 24,
	parameter int MAX_PPS_BYTES = 8,
	parameter int SPS_CW = $clog2(MAX_SPS_BYTES + 6),
	parameter int PPS_CW = $clog2(MAX_PPS_BYTES + 2),
	parameter int SPS_AW = $clog2(MAX_SPS_BYTES),
	parameter int PPS_AW = $clog2(MAX_PPS_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              head,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic              sps_we,
	input  logic [SPS_AW-1:0] sps_wa,
	input  logic              pps_we,
	input  logic [PPS_AW-1:0] pps_wa,
	input  logic [7:0]        wr_data,
	input  logic [SPS_CW-1:0] sps_cnt,
	input  logic [PPS_CW-1:0] pps_cnt,
	avcpk_out_if.source       bodies
);

	logic [7:0]  sps_mem [MAX_SPS_BYTES];
	logic [7:0]  pps_mem [MAX_PPS_BYTES];

	phase_t      ph_q, ph, ph_n;
	logic        busy_q;
	logic [5:0]  cnt_q, cnt_n;
	logic        emit;
	logic [5:0]  k;
	logic [SPS_AW-1:0] sps_ra;
	logic [7:0]  sps_rd, pps_rd;
	logic [7:0]  byte_c;
	logic [1:0]  kind_c;
	logic        eop_c;
	logic [31:0] time_c;

	logic        ov_q;
	logic [7:0]  ob_q;
	logic [1:0]  ok_q;
	logic        oe_q, oerr_q;
	logic [31:0] ot_q;

	always_ff @(posedge clk) begin
		if (sps_we)
			sps_mem[sps_wa] <= wr_data;
		if (pps_we)
			pps_mem[pps_wa] <= wr_data;
	end

	assign emit = !q_empty && (!ov_q || bodies.ready);

	always_comb begin
		if (busy_q)
			ph = ph_q;
		else if (head.do_seq)
			ph = PH_LEAD;
		else if (head.do_hdr)
			ph = PH_HDR;
		else
			ph = PH_DATA;
	end

	// next state
	always_comb begin
		ph_n = ph;
		cnt_n = cnt_q + 6'd1;
		case (ph)
			PH_LEAD: if (cnt_q == LEAD_LAST) begin
				ph_n = PH_SPS;
				cnt_n = '0;
			end
			PH_SPS: if (cnt_q == 6'(sps_cnt - SPS_CW'(1))) begin
				ph_n = PH_MID;
				cnt_n = '0;
			end
			PH_MID: if (cnt_q == MID_LAST) begin
				ph_n = PH_PPS;
				cnt_n = '0;
			end
			PH_PPS: if (cnt_q == 6'(pps_cnt - PPS_CW'(1))) begin
				ph_n = PH_HDR;
				cnt_n = '0;
			end
			PH_HDR: if (cnt_q == HDR_LAST) begin
				ph_n = PH_DATA;
				cnt_n = '0;
			end
			default: cnt_n = '0;
		endcase
	end

	// byte selection
	always_comb begin
		k = cnt_q - 6'd5;
		sps_ra = (ph == PH_LEAD) ? k[SPS_AW-1:0] : cnt_q[SPS_AW-1:0];
		sps_rd = sps_mem[sps_ra];
		pps_rd = pps_mem[cnt_q[PPS_AW-1:0]];
		byte_c = 8'h00;
		kind_c = KIND_SEQ;
		eop_c = 1'b0;
		time_c = 32'd0;
		case (ph)
			PH_LEAD: begin
				case (cnt_q)
					6'd0: byte_c = TAG_KEY;
					6'd5: byte_c = BYTE_01;
					6'd6, 6'd7, 6'd8:
						byte_c = ({{(SPS_CW > 6 ? 0 : 6 - SPS_CW){1'b0}}, sps_cnt} > 6'(k))
							? sps_rd : 8'h00;
					6'd9: byte_c = AVCC_FF;
					6'd10: byte_c = AVCC_E1;
					6'd12: byte_c = 8'(sps_cnt);
					default: byte_c = 8'h00;
				endcase
			end
			PH_SPS: byte_c = sps_rd;
			PH_MID: begin
				case (cnt_q)
					6'd0: byte_c = BYTE_01;
					6'd2: byte_c = 8'(pps_cnt);
					default: byte_c = 8'h00;
				endcase
			end
			PH_PPS: begin
				byte_c = pps_rd;
				eop_c = cnt_q == 6'(pps_cnt - PPS_CW'(1));
			end
			PH_HDR: begin
				kind_c = head.kind;
				time_c = head.tstamp;
				case (cnt_q)
					6'd0: byte_c = (head.kind == KIND_KEY) ? TAG_KEY : TAG_INTER;
					6'd1: byte_c = BYTE_01;
					6'd6: byte_c = head.len[23:16];
					6'd7: byte_c = head.len[15:8];
					6'd8: byte_c = head.len[7:0];
					default: byte_c = 8'h00;
				endcase
			end
			default: begin
				byte_c = head.data;
				kind_c = head.kind;
				eop_c = head.eop;
				time_c = head.tstamp;
			end
		endcase
	end

	assign q_pop = emit && ph == PH_DATA;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= PH_DATA;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q <= ph != PH_DATA;
				ph_q <= ph_n;
				cnt_q <= cnt_n;
			end
			ov_q <= emit || (ov_q && !bodies.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q <= byte_c;
			ok_q <= kind_c;
			oe_q <= eop_c;
			ot_q <= time_c;
			oerr_q <= head.err;
		end
	end

	assign bodies.valid = ov_q;
	assign bodies.out_byte = ob_q;
	assign bodies.packet_kind = ok_q;
	assign bodies.end_of_packet = oe_q;
	assign bodies.packet_time = ot_q;
	assign bodies.param_error = oerr_q;

	ap_busy_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !q_empty) else $error("sequencer busy with empty queue");
	ap_sps_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		emit && ph == PH_SPS |-> sps_cnt != '0) else $error("empty SPS in header");
	ap_pop_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !busy_q) else $error("sequencer left busy after pop");

endmodule

@@ rtl/core/h264_annexb_to_flv_avc_packetizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_annexb_to_flv_avc_packetizer_core
// Converts Annex-B H.264 frames into FLV AVC video tag bodies.
// ----------------------------------------------------------------------------
// Input bytes are taken one per cycle while the four-entry command queue has
// room. The body sequencer sends one byte per cycle while the output is ready,
// so a frame body is one byte per payload byte plus 9 bytes of tag header at the
// frame start; a key frame with cached parameter sets adds 16 + SPS + PPS
// header bytes (at most 48 with default sizes). During those bursts the
// queue fills and input stalls; the single output byte port sets the rate.
// SPS/PPS frames are consumed with no output.
module h264_annexb_to_flv_avc_packetizer_core import avcpk_pkg::*; #(
	parameter int MAX_SPS_BYTES = 24,
	parameter int MAX_PPS_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	avcpk_in_if.sink    frames,
	avcpk_out_if.source bodies
);

	localparam int SPS_CW = $clog2(MAX_SPS_BYTES + 6);
	localparam int PPS_CW = $clog2(MAX_PPS_BYTES + 2);
	localparam int SPS_AW = $clog2(MAX_SPS_BYTES);
	localparam int PPS_AW = $clog2(MAX_PPS_BYTES);

	cmd_t              wr_cmd, head;
	logic              push, pop, q_empty, q_full;
	logic              sps_we, pps_we;
	logic [SPS_AW-1:0] sps_wa;
	logic [PPS_AW-1:0] pps_wa;
	logic [7:0]        wr_data;
	logic [SPS_CW-1:0] sps_cnt;
	logic [PPS_CW-1:0] pps_cnt;

	avcpk_front #(
		.MAX_SPS_BYTES(MAX_SPS_BYTES),
		.MAX_PPS_BYTES(MAX_PPS_BYTES)
	) u_front (
		.clk(clk), .arst_n(arst_n), .frames(frames),
		.q_full(q_full), .q_push(push), .q_cmd(wr_cmd),
		.sps_we(sps_we), .sps_wa(sps_wa), .pps_we(pps_we), .pps_wa(pps_wa),
		.wr_data(wr_data), .sps_cnt(sps_cnt), .pps_cnt(pps_cnt)
	);

	avcpk_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_cmd(wr_cmd),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	avcpk_back #(
		.MAX_SPS_BYTES(MAX_SPS_BYTES),
		.MAX_PPS_BYTES(MAX_PPS_BYTES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(q_empty), .q_pop(pop),
		.sps_we(sps_we), .sps_wa(sps_wa), .pps_we(pps_we), .pps_wa(pps_wa),
		.wr_data(wr_data), .sps_cnt(sps_cnt), .pps_cnt(pps_cnt), .bodies(bodies)
	);

endmodule

@@ tb/sv/tb_h264_annexb_to_flv_avc_packetizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_h264_annexb_to_flv_avc_packetizer_core
// Drives Annex-B frames byte by byte and checks every FLV body byte against a
// predictor of the packetizer. A short table of directed frames comes first,
// then random frames with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_h264_annexb_to_flv_avc_packetizer_core;
	import avcpk_pkg::*;

	localparam int SPS_MAX = 24;
	localparam int PPS_MAX = 8;
	localparam int WDOG_LIMIT = 4000;
	localparam int ITEMS = 130;

	typedef struct packed {
		logic [7:0]  data;
		logic [1:0]  kind;
		logic        eop;
		logic [31:0] tstamp;
		logic        err;
	} body_byte_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [23:0] flen;
		logic [31:0] ts;
	} annexb_byte_t;

	typedef enum {
		ROW_FRAME,
		ROW_PARAM,
		ROW_IDLE
	} row_op_t;

	// ROW_FRAME: n NAL bytes after the start code; ROW_PARAM: n SPS and m PPS
	// bytes; ROW_IDLE: one stray byte nal[0]
	typedef struct {
		row_op_t     op;
		int          n;
		int          m;
		logic [7:0]  nal [4];
		logic [23:0] flen;
		logic [31:0] ts;
		bit          mark_last;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	avcpk_in_if  frames();
	avcpk_out_if bodies();

	h264_annexb_to_flv_avc_packetizer_core #(
		.MAX_SPS_BYTES(SPS_MAX),
		.MAX_PPS_BYTES(PPS_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frames(frames),
		.bodies(bodies)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [7:0]  p_sps [SPS_MAX];
	logic [7:0]  p_pps [PPS_MAX];
	int unsigned p_sps_cnt, p_pps_cnt;
	bit          p_cached, p_in_pps, p_err;
	int unsigned p_pos;
	logic [31:0] p_recent;
	frame_mode_t p_mode;
	logic [23:0] p_len;
	logic [31:0] p_time;
	logic [1:0]  p_kind;
	bit          p_mute = 1'b0;

	body_byte_t  pending_bodies[$];
	annexb_byte_t stim[$];
	int          typed_len = 0;
	int          fails = 0;
	int          idle_cycles = 0;
	int          out_hold = 0;

	// directed frames; the first row has typed-in expectations
	dir_row_t dir_rows [10] = '{
		// key frame with nothing cached: tag only, length 2
		'{ROW_FRAME, 2, 0, '{NAL_IDR, 8'hAB, 8'h00, 8'h00}, 24'd6, 32'hFFFF_FFFF, 1'b1},
		// inter frame, frame_len below four: length field zero, ends on NAL byte
		'{ROW_FRAME, 3, 0, '{8'h41, 8'h00, 8'hFF, 8'h00}, 24'd3, 32'h0, 1'b1},
		// frame ends before NAL byte
		'{ROW_FRAME, 0, 0, '{8'h00, 8'h00, 8'h00, 8'h00}, 24'd5, 32'h1, 1'b1},
		// capture without 0x68
		'{ROW_FRAME, 4, 0, '{NAL_SPS, 8'h42, 8'h00, 8'h1E}, 24'd8, 32'h0, 1'b1},
		// oversized PPS sets the error flag
		'{ROW_PARAM, 2, PPS_MAX, '{8'h00, 8'h00, 8'h00, 8'h00}, 24'd0, 32'h0, 1'b1},
		// short SPS gets cached and clears the error
		'{ROW_PARAM, 1, 1, '{8'h00, 8'h00, 8'h00, 8'h00}, 24'd0, 32'h0, 1'b1},
		// key frame with sequence header
		'{ROW_FRAME, 3, 0, '{NAL_IDR, 8'h01, 8'h02, 8'h00}, 24'd7, 32'h1234, 1'b1},
		// max frame_len; abandoned mid-frame by a new first
		'{ROW_FRAME, 3, 0, '{8'h41, 8'h5A, 8'hA5, 8'h00}, 24'hFFFFFF, 32'h8000_0001, 1'b0},
		// 0x67 again while cached is ignored
		'{ROW_PARAM, 1, 1, '{8'h00, 8'h00, 8'h00, 8'h00}, 24'd0, 32'h0, 1'b1},
		// byte while idle
		'{ROW_IDLE, 1, 0, '{8'hEE, 8'h00, 8'h00, 8'h00}, 24'd9, 32'd9, 1'b1}
	};

	task automatic push_body(input logic [7:0] d, input logic [1:0] k, input bit e,
			input logic [31:0] t);
		body_byte_t r;
		r.data = d; r.kind = k; r.eop = e; r.tstamp = t; r.err = p_err;
		if (!p_mute)
			pending_bodies.push_back(r);
	endtask

	task automatic predict_seq_header();
		logic [7:0] lead [6];
		lead = '{TAG_KEY, 8'h00, 8'h00, 8'h00, 8'h00, BYTE_01};
		foreach (lead[k]) push_body(lead[k], KIND_SEQ, 0, 0);
		for (int k = 1; k <= 3; k++)
			push_body((k < p_sps_cnt) ? p_sps[k] : 8'h00, KIND_SEQ, 0, 0);
		push_body(AVCC_FF, KIND_SEQ, 0, 0);
		push_body(AVCC_E1, KIND_SEQ, 0, 0);
		push_body(p_sps_cnt[15:8], KIND_SEQ, 0, 0);
		push_body(p_sps_cnt[7:0], KIND_SEQ, 0, 0);
		for (int k = 0; k < p_sps_cnt && k < SPS_MAX; k++) push_body(p_sps[k], KIND_SEQ, 0, 0);
		push_body(BYTE_01, KIND_SEQ, 0, 0);
		push_body(p_pps_cnt[15:8], KIND_SEQ, 0, 0);
		push_body(p_pps_cnt[7:0], KIND_SEQ, 0, 0);
		for (int k = 0; k < p_pps_cnt && k < PPS_MAX; k++)
			push_body(p_pps[k], KIND_SEQ, k + 1 == p_pps_cnt, 0);
	endtask

	task automatic capture_param_byte(input logic [7:0] b);
		if (!p_in_pps) begin
			if (p_sps_cnt >= 5 && p_recent == 32'h1 && b == NAL_PPS) begin
				p_sps_cnt -= 4;
				p_in_pps = 1;
				p_pps_cnt = 0;
			end else begin
				if (p_sps_cnt < SPS_MAX) p_sps[p_sps_cnt] = b;
				if (p_sps_cnt < SPS_MAX + 5) p_sps_cnt++;
				return;
			end
		end
		if (p_pps_cnt < PPS_MAX) p_pps[p_pps_cnt] = b;
		if (p_pps_cnt < PPS_MAX + 1) p_pps_cnt++;
	endtask

	task automatic predict_packetizer(input annexb_byte_t x);
		int unsigned p;
		logic [31:0] len;
		bit fend;
		if (x.first) begin
			p_pos = 0;
			p_mode = FM_START;
		end
		p = p_pos;
		if (p_mode == FM_START) begin
			if (p >= 4) begin
				p_len = x.flen;
				p_time = x.ts;
				if (x.data == NAL_SPS) begin
					if (p_cached) p_mode = FM_IDLE;
					else begin
						p_mode = FM_CAPTURE;
						p_sps_cnt = 0;
						p_pps_cnt = 0;
						p_in_pps = 0;
					end
				end else begin
					len = (p_len >= 4) ? p_len - 4 : 0;
					p_kind = (x.data == NAL_IDR) ? KIND_KEY : KIND_INTER;
					if (p_kind == KIND_KEY && p_cached) predict_seq_header();
					push_body(p_kind == KIND_KEY ? TAG_KEY : TAG_INTER, p_kind, 0, p_time);
					push_body(BYTE_01, p_kind, 0, p_time);
					push_body(8'h00, p_kind, 0, p_time);
					push_body(8'h00, p_kind, 0, p_time);
					push_body(8'h00, p_kind, 0, p_time);
					push_body(len[31:24], p_kind, 0, p_time);
					push_body(len[23:16], p_kind, 0, p_time);
					push_body(len[15:8], p_kind, 0, p_time);
					push_body(len[7:0], p_kind, 0, p_time);
					p_mode = FM_TAG;
				end
			end else if (x.last) p_mode = FM_IDLE;
		end
		if (p_mode == FM_CAPTURE || p_mode == FM_TAG) begin
			fend = x.last || (p + 1 >= p_len);
			if (p_mode == FM_CAPTURE) begin
				capture_param_byte(x.data);
				if (fend) begin
					if (p_in_pps && p_sps_cnt <= SPS_MAX && p_pps_cnt <= PPS_MAX) begin
						p_cached = 1;
						p_err = 0;
					end else begin
						if (p_in_pps) p_err = 1;
						p_sps_cnt = 0;
						p_pps_cnt = 0;
					end
				end
			end else push_body(x.data, p_kind, fend, p_time);
			if (fend) p_mode = FM_IDLE;
		end
		p_recent = {p_recent[23:0], x.data};
		if (p_pos < 24'hFFFFFF) p_pos++;
	endtask

	// Queue one frame. len_field is what frame_len carries; the start code and all
	// nal bytes are sent (last_of_frame on the final one when mark_last).
	task automatic add_frame(input logic [7:0] nal[$], input logic [23:0] len_field,
			input logic [31:0] ts, input bit mark_last);
		annexb_byte_t x;
		logic [7:0] bytes[$];
		bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
		bytes = {bytes, nal};
		foreach (bytes[i]) begin
			x.data = bytes[i];
			x.first = (i == 0);
			x.last = mark_last && (i == bytes.size() - 1);
			x.flen = len_field;
			x.ts = ts;
			stim.push_back(x);
		end
	endtask

	function automatic void rand_bytes(ref logic [7:0] q[$], input int n);
		repeat (n) q.push_back(8'($urandom_range(0, 255)));
	endfunction

	// SPS/PPS frame: sps bytes after 0x67, then start code, 0x68, pps bytes
	task automatic add_param_frame(input int sps_n, input int pps_n, input bit mark_last);
		logic [7:0] nal[$];
		nal = '{NAL_SPS};
		rand_bytes(nal, sps_n);
		foreach (nal[i]) if (i > 0 && nal[i] == 8'h01) nal[i] = 8'h02;
		nal = {nal, 8'h00, 8'h00, 8'h00, 8'h01, NAL_PPS};
		rand_bytes(nal, pps_n);
		add_frame(nal, 24'(nal.size() + 4), $urandom, mark_last);
	endtask

	task automatic add_video_frame(input logic [7:0] nal_type, input int n);
		logic [7:0] nal[$];
		nal = '{nal_type};
		rand_bytes(nal, n);
		add_frame(nal, 24'(nal.size() + 4), $urandom, $urandom_range(0, 1) == 1);
	endtask

	task automatic build_directed();
		logic [7:0] nal[$];
		annexb_byte_t x;
		foreach (dir_rows[r]) begin
			case (dir_rows[r].op)
				ROW_FRAME: begin
					nal = {};
					for (int i = 0; i < dir_rows[r].n; i++) nal.push_back(dir_rows[r].nal[i]);
					add_frame(nal, dir_rows[r].flen, dir_rows[r].ts, dir_rows[r].mark_last);
				end
				ROW_PARAM: add_param_frame(dir_rows[r].n, dir_rows[r].m, dir_rows[r].mark_last);
				default: begin
					x = '{dir_rows[r].nal[0], 1'b0, dir_rows[r].mark_last, dir_rows[r].flen,
						dir_rows[r].ts};
					stim.push_back(x);
				end
			endcase
			if (r == 0)
				typed_len = stim.size();
		end
	endtask

	// extra ignored bytes and frame-length cut in random part
	task automatic build_random();
		while (stim.size() < ITEMS) begin
			case ($urandom_range(0, 9))
				0: add_param_frame($urandom_range(1, SPS_MAX + 1), $urandom_range(0, PPS_MAX + 1),
					$urandom_range(0, 1) == 1);
				1, 2, 3: add_video_frame(NAL_IDR, $urandom_range(0, 6));
				4: begin
					logic [7:0] nal[$];
					nal = '{8'h41};
					rand_bytes(nal, $urandom_range(0, 4));
					add_frame(nal, 24'($urandom_range(0, 24'hFFFFFF)), $urandom, 1);
				end
				5: begin
					logic [7:0] nal[$];
					rand_bytes(nal, $urandom_range(0, 5));
					add_frame(nal, 24'($urandom_range(5, 12)), $urandom,
						$urandom_range(0, 1) == 1);
				end
				default: add_video_frame(8'($urandom_range(0, 255)), $urandom_range(0, 5));
			endcase
		end
	endtask

	// expected outputs of the first frame: key frame, nothing cached, length 2
	body_byte_t typed_first[$];

	initial begin
		frames.valid = 1'b0;
		frames.in_byte = '0;
		frames.first_of_frame = 1'b0;
		frames.last_of_frame = 1'b0;
		frames.frame_len = '0;
		frames.timestamp = '0;
		bodies.ready = 1'b0;
		p_sps_cnt = 0; p_pps_cnt = 0; p_cached = 0; p_in_pps = 0; p_err = 0;
		p_pos = 0; p_recent = 0; p_mode = FM_IDLE; p_len = 0; p_time = 0; p_kind = 0;
		foreach (p_sps[i]) p_sps[i] = 0;
		foreach (p_pps[i]) p_pps[i] = 0;
		typed_first = '{
			'{TAG_KEY, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{BYTE_01, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{8'h00, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{8'h00, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{8'h00, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{8'h00, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{8'h00, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{8'h00, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{8'h02, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{NAL_IDR, KIND_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0},
			'{8'hAB, KIND_KEY, 1'b1, 32'hFFFF_FFFF, 1'b0}
		};
		build_directed();
		build_random();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// source side
	initial begin
		int gap;
		int idx;
		@(posedge arst_n);
		idx = 0;
		while (idx < stim.size()) begin
			@(posedge clk);
			if (frames.valid && frames.ready) begin
				// the first frame's bodies are typed in; the predictor only tracks state
				if (idx == 0)
					foreach (typed_first[i]) pending_bodies.push_back(typed_first[i]);
				p_mute = (idx < typed_len);
				predict_packetizer(stim[idx]);
				p_mute = 1'b0;
				idx++;
			end
			if (!frames.valid || frames.ready) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) :
					($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0);
				if (idx < stim.size() && gap == 0) begin
					frames.valid <= 1'b1;
					frames.in_byte <= stim[idx].data;
					frames.first_of_frame <= stim[idx].first;
					frames.last_of_frame <= stim[idx].last;
					frames.frame_len <= stim[idx].flen;
					frames.timestamp <= stim[idx].ts;
				end else begin
					frames.valid <= 1'b0;
					if (idx < stim.size()) begin
						repeat (gap - 1) @(posedge clk);
					end
				end
			end
		end
		frames.valid <= 1'b0;
		while (pending_bodies.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	// sink side: random stalls, compare on transfer
	always @(posedge clk) begin
		body_byte_t want;
		if (arst_n && bodies.valid && bodies.ready) begin
			if (pending_bodies.size() == 0) begin
				$error("unexpected body byte %h", bodies.out_byte);
				fails++;
			end else begin
				want = pending_bodies.pop_front();
				if (bodies.out_byte !== want.data) begin
					$error("out_byte exp %h got %h", want.data, bodies.out_byte); fails++;
				end
				if (bodies.packet_kind !== want.kind) begin
					$error("packet_kind exp %0d got %0d", want.kind, bodies.packet_kind); fails++;
				end
				if (bodies.end_of_packet !== want.eop) begin
					$error("end_of_packet exp %b got %b", want.eop, bodies.end_of_packet); fails++;
				end
				if (bodies.packet_time !== want.tstamp) begin
					$error("packet_time exp %h got %h", want.tstamp, bodies.packet_time); fails++;
				end
				if (bodies.param_error !== want.err) begin
					$error("param_error exp %b got %b", want.err, bodies.param_error); fails++;
				end
			end
		end
		if (arst_n) begin
			// mostly short stalls, now and then a long one
			if (out_hold > 0) begin
				out_hold--;
				bodies.ready <= 1'b0;
			end else if ($urandom_range(0, 29) == 0) begin
				out_hold = $urandom_range(5, 30);
				bodies.ready <= 1'b0;
			end else
				bodies.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((frames.valid && frames.ready) || (bodies.valid && bodies.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
